### rtl/etm_pkg.sv
// Shared types, constants and register codes of the endstop trigger monitor.
`default_nettype none

package etm_pkg;

  localparam int NumPins      = 13;
  localparam int PinIdxW      = 4;
  localparam int NumAxes      = 3;
  localparam int NumHits      = 4;
  localparam int MaxZSwitches = 4;

  // Pin positions in the raw pin word.
  localparam logic [PinIdxW-1:0] PinXMin  = 4'd0;
  localparam logic [PinIdxW-1:0] PinYMin  = 4'd1;
  localparam logic [PinIdxW-1:0] PinProbe = 4'd3;
  localparam logic [PinIdxW-1:0] PinXMax  = 4'd4;
  localparam logic [PinIdxW-1:0] PinYMax  = 4'd5;

  localparam logic [PinIdxW-1:0] ZMinPins [MaxZSwitches] = '{4'd2, 4'd7, 4'd9, 4'd11};
  localparam logic [PinIdxW-1:0] ZMaxPins [MaxZSwitches] = '{4'd6, 4'd8, 4'd10, 4'd12};

  // Hit flag positions.
  localparam int HitX     = 0;
  localparam int HitY     = 1;
  localparam int HitZ     = 2;
  localparam int HitProbe = 3;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgInvertMask  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPresentMask = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgZSwitchCnt  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgProbeMode   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgProbeEnable = 3'd4;

  // Probe modes.
  localparam logic [1:0] ProbeNone     = 2'd0;
  localparam logic [1:0] ProbeOnZMin   = 2'd1;
  localparam logic [1:0] ProbeSeparate = 2'd2;

  localparam logic [NumPins-1:0] PresentReset = 13'd127;
  localparam logic [2:0]         ZCountReset  = 3'd1;

  typedef struct packed {
    logic [NumPins-1:0] invert_mask;
    logic [NumPins-1:0] present_mask;
    logic [2:0]         z_switch_count;
    logic [1:0]         probe_mode;
    logic               probe_enable;
  } etm_cfg_t;

  typedef struct packed {
    logic [NumPins-1:0] raw_pins;
    logic [NumAxes-1:0] dir_negative;
    logic [NumAxes-1:0] axis_moving;
    logic               homing;
    logic               clear_hits;
  } etm_item_t;

  typedef struct packed {
    logic [NumPins-1:0] sampled_levels;
    logic [NumHits-1:0] hit_flags;
    logic [NumAxes-1:0] stop_axes;
    logic               abort_move;
  } etm_result_t;

endpackage

`default_nettype wire

### rtl/endstop_trigger_monitor.sv
// Top level of the endstop trigger monitor: request registers, state and result register.
`default_nettype none

// The monitor takes one request per stepper tick: 13 raw endstop pin levels,
// the per-axis direction and moving flags, the homing flag and a request to
// clear the sticky hits. Only the endstops that face the direction of motion
// are sampled, after polarity inversion, and a switch counts as triggered
// when it reads active on this sample and on the previous one. Each request
// yields exactly one result with the updated level word, the sticky hit
// flags, the axes to stop and the abort flag of the combined multi-Z test.
// A request is registered on acceptance and its result is registered when the
// result register is free, and a new request is accepted every clock as long
// as the result side keeps taking results; the input stall rises only when
// both the request register and the result register are full and the result
// is stalled. The level and hit state is updated in the same cycle a request
// moves into the result register, so the next request always sees it.
// Configuration writes are always ready and take effect on the next clock;
// write them only while the monitor holds no request. Writes to indexes
// beyond the five registers are ignored.

module endstop_trigger_monitor
  import etm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [NumPins-1:0] cfg_data_i,
  // Request channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [NumPins-1:0] raw_pins_i,
  input  wire logic [NumAxes-1:0] dir_negative_i,
  input  wire logic [NumAxes-1:0] axis_moving_i,
  input  wire logic               homing_i,
  input  wire logic               clear_hits_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [NumPins-1:0]      sampled_levels_o,
  output logic [NumHits-1:0]      hit_flags_o,
  output logic [NumAxes-1:0]      stop_axes_o,
  output logic                    abort_move_o
);

  etm_cfg_t           cfg;
  etm_item_t          item_q;
  etm_result_t        result_d;
  etm_result_t        result_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               out_free;
  logic               advance;
  logic               accept;
  logic [NumPins-1:0] last_levels_q;
  logic [NumHits-1:0] sticky_hits_q;

  etm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // The result register can take a new result when it is empty or drains now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.raw_pins     <= raw_pins_i;
      item_q.dir_negative <= dir_negative_i;
      item_q.axis_moving  <= axis_moving_i;
      item_q.homing       <= homing_i;
      item_q.clear_hits   <= clear_hits_i;
    end
  end

  etm_core u_core (
    .cfg_i         (cfg),
    .item_i        (item_q),
    .last_levels_i (last_levels_q),
    .sticky_hits_i (sticky_hits_q),
    .result_o      (result_d)
  );

  // Level and hit state follows each request as it enters the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_levels_q <= '0;
      sticky_hits_q <= '0;
    end else if (advance) begin
      last_levels_q <= result_d.sampled_levels;
      sticky_hits_q <= result_d.hit_flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sampled_levels_o = result_q.sampled_levels;
  assign hit_flags_o      = result_q.hit_flags;
  assign stop_axes_o      = result_q.stop_axes;
  assign abort_move_o     = result_q.abort_move;

endmodule

`default_nettype wire

### rtl/etm_cfg_regs.sv
// Configuration register file of the endstop trigger monitor.
`default_nettype none

module etm_cfg_regs
  import etm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [NumPins-1:0] cfg_data_i,
  output etm_cfg_t                cfg_o
);

  etm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgInvertMask:  cfg_d.invert_mask    = cfg_data_i;
        CfgPresentMask: cfg_d.present_mask   = cfg_data_i;
        CfgZSwitchCnt:  cfg_d.z_switch_count = cfg_data_i[2:0];
        CfgProbeMode:   cfg_d.probe_mode     = cfg_data_i[1:0];
        CfgProbeEnable: cfg_d.probe_enable   = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert_mask    <= '0;
      cfg_q.present_mask   <= PresentReset;
      cfg_q.z_switch_count <= ZCountReset;
      cfg_q.probe_mode     <= ProbeNone;
      cfg_q.probe_enable   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/etm_core.sv
// Combinational endstop sampling, trigger qualification and hit logic.
`default_nettype none

module etm_core
  import etm_pkg::*;
(
  input  wire etm_cfg_t           cfg_i,
  input  wire etm_item_t          item_i,
  input  wire logic [NumPins-1:0] last_levels_i,
  input  wire logic [NumHits-1:0] sticky_hits_i,
  output etm_result_t             result_o
);

  logic [NumPins-1:0]      active;
  logic [NumPins-1:0]      prev;
  logic [NumPins-1:0]      cur;
  logic [NumHits-1:0]      hits;
  logic [NumAxes-1:0]      stop;
  logic                    abort_mv;
  logic [2:0]              count;
  logic                    down;
  logic                    z_moving;
  logic [PinIdxW-1:0]      x_pin;
  logic [PinIdxW-1:0]      y_pin;
  logic [PinIdxW-1:0]      z_pins [MaxZSwitches];
  logic [MaxZSwitches-1:0] z_test;
  logic [MaxZSwitches-1:0] z_all;

  always_comb begin
    active   = item_i.raw_pins ^ cfg_i.invert_mask;
    prev     = last_levels_i;
    cur      = prev;
    hits     = item_i.clear_hits ? '0 : sticky_hits_i;
    stop     = '0;
    abort_mv = 1'b0;
    down     = item_i.dir_negative[2];
    z_moving = item_i.axis_moving[2];
    z_test   = '0;

    // Out-of-range switch counts saturate into one to four.
    if (cfg_i.z_switch_count == 3'd0) begin
      count = 3'd1;
    end else if (cfg_i.z_switch_count > 3'(MaxZSwitches)) begin
      count = 3'(MaxZSwitches);
    end else begin
      count = cfg_i.z_switch_count;
    end

    for (int k = 0; k < MaxZSwitches; k++) begin
      z_pins[k] = down ? ZMinPins[k] : ZMaxPins[k];
      z_all[k]  = (3'(k) < count);
    end

    // X and Y have a single switch per direction.
    x_pin = item_i.dir_negative[0] ? PinXMin : PinXMax;
    y_pin = item_i.dir_negative[1] ? PinYMin : PinYMax;
    if (cfg_i.present_mask[x_pin]) begin
      cur[x_pin] = active[x_pin];
      if (prev[x_pin] && active[x_pin] && item_i.axis_moving[0]) begin
        hits[HitX] = 1'b1;
        stop[0]    = 1'b1;
      end
    end
    if (cfg_i.present_mask[y_pin]) begin
      cur[y_pin] = active[y_pin];
      if (prev[y_pin] && active[y_pin] && item_i.axis_moving[1]) begin
        hits[HitY] = 1'b1;
        stop[1]    = 1'b1;
      end
    end

    if (cfg_i.present_mask[z_pins[0]]) begin
      if (count >= 3'd2) begin
        // Combined Z test; absent extra switches follow the primary one.
        cur[z_pins[0]] = active[z_pins[0]];
        for (int k = 1; k < MaxZSwitches; k++) begin
          if (z_all[k]) begin
            cur[z_pins[k]] = cfg_i.present_mask[z_pins[k]] ? active[z_pins[k]]
                                                           : active[z_pins[0]];
          end
        end
        for (int k = 0; k < MaxZSwitches; k++) begin
          z_test[k] = z_all[k] & cur[z_pins[k]] & prev[z_pins[k]];
        end
        if ((z_test != '0) && z_moving) begin
          hits[HitZ] = 1'b1;
          if (!item_i.homing || (z_test == z_all)) begin
            abort_mv = 1'b1;
          end
        end
      end else if (!(down && (cfg_i.probe_mode == ProbeOnZMin) && !cfg_i.probe_enable)) begin
        cur[z_pins[0]] = active[z_pins[0]];
        if (prev[z_pins[0]] && active[z_pins[0]] && z_moving) begin
          hits[HitZ] = 1'b1;
          stop[2]    = 1'b1;
        end
      end
    end

    if (down && (cfg_i.probe_mode == ProbeSeparate) && cfg_i.probe_enable) begin
      cur[PinProbe] = active[PinProbe];
      if (prev[PinProbe] && active[PinProbe]) begin
        if (z_moving) begin
          hits[HitZ] = 1'b1;
          stop[2]    = 1'b1;
        end
        hits[HitProbe] = 1'b1;
      end
    end

    result_o.sampled_levels = cur;
    result_o.hit_flags      = hits;
    result_o.stop_axes      = stop;
    result_o.abort_move     = abort_mv;
  end

endmodule

`default_nettype wire

### bench/endstop_watch.sv
// Checker of the endstop trigger monitor: watches the channels, predicts each result and compares.
`timescale 1ns / 1ps

module endstop_watch
  import etm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [NumPins-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [NumPins-1:0] raw_pins_i,
  input  wire logic [NumAxes-1:0] dir_negative_i,
  input  wire logic [NumAxes-1:0] axis_moving_i,
  input  wire logic               homing_i,
  input  wire logic               clear_hits_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [NumPins-1:0] sampled_levels_i,
  input  wire logic [NumHits-1:0] hit_flags_i,
  input  wire logic [NumAxes-1:0] stop_axes_i,
  input  wire logic               abort_move_i,
  output int                      fault_count_o,
  output int                      outstanding_o
);

  // Shadow copy of the configuration registers.
  logic [NumPins-1:0] invert_r;
  logic [NumPins-1:0] present_r;
  logic [2:0]         zcount_r;
  logic [1:0]         pmode_r;
  logic               pen_r;

  // Predicted state of the monitor.
  logic [NumPins-1:0] levels_r;
  logic [NumHits-1:0] hits_r;

  etm_result_t due_results [$];
  etm_result_t want;
  etm_item_t   tick;
  int          faults;

  // Works out the result of one request and advances the predicted state.
  function automatic etm_result_t next_tick_result(input etm_item_t it);
    logic [NumPins-1:0]     active;
    logic [NumPins-1:0]     prev;
    logic [NumPins-1:0]     cur;
    logic [NumAxes-1:0]     stop;
    logic                   abort_mv;
    logic                   down;
    logic                   z_moving;
    logic                   probe_gated;
    logic [MaxZSwitches-1:0] z_test;
    logic [MaxZSwitches-1:0] z_all;
    logic [PinIdxW-1:0]     zp [MaxZSwitches];
    int                     cnt;
    int                     pin;
    etm_result_t            res;

    active   = it.raw_pins ^ invert_r;
    prev     = levels_r;
    cur      = prev;
    stop     = '0;
    abort_mv = 1'b0;
    if (it.clear_hits) hits_r = '0;
    cnt = int'(zcount_r);
    if (cnt < 1) cnt = 1;
    if (cnt > MaxZSwitches) cnt = MaxZSwitches;

    for (int axis = 0; axis < 2; axis++) begin
      pin = it.dir_negative[axis] ? axis : axis + 4;
      if (present_r[pin]) begin
        cur[pin] = active[pin];
        if (cur[pin] && prev[pin] && it.axis_moving[axis]) begin
          hits_r[axis] = 1'b1;
          stop[axis]   = 1'b1;
        end
      end
    end

    down     = it.dir_negative[2];
    z_moving = it.axis_moving[2];
    for (int k = 0; k < MaxZSwitches; k++) zp[k] = down ? ZMinPins[k] : ZMaxPins[k];
    // With the probe on the Z min pin, a single Z min switch is read only when probing is on.
    probe_gated = down && pmode_r == ProbeOnZMin && !pen_r;

    if (present_r[zp[0]]) begin
      if (cnt >= 2) begin
        z_test = '0;
        z_all  = MaxZSwitches'((1 << cnt) - 1);
        cur[zp[0]] = active[zp[0]];
        // Extra Z switches that do not exist follow the primary one.
        for (int k = 1; k < cnt; k++)
          cur[zp[k]] = present_r[zp[k]] ? active[zp[k]] : cur[zp[0]];
        for (int k = 0; k < cnt; k++) z_test[k] = cur[zp[k]] & prev[zp[k]];
        if (z_test != '0 && z_moving) begin
          hits_r[HitZ] = 1'b1;
          if (!it.homing || z_test == z_all) abort_mv = 1'b1;
        end
      end else if (!probe_gated) begin
        cur[zp[0]] = active[zp[0]];
        if (cur[zp[0]] && prev[zp[0]] && z_moving) begin
          hits_r[HitZ] = 1'b1;
          stop[2]      = 1'b1;
        end
      end
    end

    if (down && pmode_r == ProbeSeparate && pen_r) begin
      cur[PinProbe] = active[PinProbe];
      if (cur[PinProbe] && prev[PinProbe]) begin
        if (z_moving) begin
          hits_r[HitZ] = 1'b1;
          stop[2]      = 1'b1;
        end
        hits_r[HitProbe] = 1'b1;
      end
    end

    levels_r           = cur;
    res.sampled_levels = cur;
    res.hit_flags      = hits_r;
    res.stop_axes      = stop;
    res.abort_move     = abort_mv;
    return res;
  endfunction

  task automatic flag_field(input string field, input int unsigned exp_v,
                            input int unsigned got_v);
    faults++;
    if (faults <= 10)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, exp_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_r  = '0;
      present_r = PresentReset;
      zcount_r  = ZCountReset;
      pmode_r   = ProbeNone;
      pen_r     = 1'b0;
      levels_r  = '0;
      hits_r    = '0;
      faults    = 0;
      due_results.delete();
      fault_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          faults++;
          if (faults <= 10) $display("%0t: result with no request waiting for it", $realtime);
        end else begin
          want = due_results.pop_front();
          if (sampled_levels_i !== want.sampled_levels)
            flag_field("sampled_levels", want.sampled_levels, sampled_levels_i);
          if (hit_flags_i !== want.hit_flags)
            flag_field("hit_flags", want.hit_flags, hit_flags_i);
          if (stop_axes_i !== want.stop_axes)
            flag_field("stop_axes", want.stop_axes, stop_axes_i);
          if (abort_move_i !== want.abort_move)
            flag_field("abort_move", want.abort_move, abort_move_i);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        tick.raw_pins     = raw_pins_i;
        tick.dir_negative = dir_negative_i;
        tick.axis_moving  = axis_moving_i;
        tick.homing       = homing_i;
        tick.clear_hits   = clear_hits_i;
        due_results.push_back(next_tick_result(tick));
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgInvertMask:  invert_r  = cfg_data_i;
          CfgPresentMask: present_r = cfg_data_i;
          CfgZSwitchCnt:  zcount_r  = cfg_data_i[2:0];
          CfgProbeMode:   pmode_r   = cfg_data_i[1:0];
          CfgProbeEnable: pen_r     = cfg_data_i[0];
          default: ;
        endcase
      end

      fault_count_o <= faults;
      outstanding_o <= due_results.size();
    end
  end

endmodule

### bench/tb.sv
// Testbench top of the endstop trigger monitor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb
  import etm_pkg::*;
();

  // Watchdog limit; the run needs far less, so this leaves ample room.
  localparam int CycleLimit   = 200000;
  // Length of the one long hold-off on the result side.
  localparam int LongHold     = 300;
  localparam int RandomPhases = 8;
  localparam int PhaseTicks   = 85;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index    = '0;
  logic [NumPins-1:0] cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [NumPins-1:0] raw_pins     = '0;
  logic [NumAxes-1:0] dir_negative = '0;
  logic [NumAxes-1:0] axis_moving  = '0;
  logic               homing       = 1'b0;
  logic               clear_hits   = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [NumPins-1:0] sampled_levels;
  logic [NumHits-1:0] hit_flags;
  logic [NumAxes-1:0] stop_axes;
  logic               abort_move;

  int fault_count;
  int outstanding;
  int cycle_count = 0;
  int sent_count  = 0;
  // Once set, neither side idles any more.
  bit calm        = 1'b0;
  bit hold_done   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  endstop_trigger_monitor dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .raw_pins_i       (raw_pins),
    .dir_negative_i   (dir_negative),
    .axis_moving_i    (axis_moving),
    .homing_i         (homing),
    .clear_hits_i     (clear_hits),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .sampled_levels_o (sampled_levels),
    .hit_flags_o      (hit_flags),
    .stop_axes_o      (stop_axes),
    .abort_move_o     (abort_move)
  );

  // The checker sits beside the monitor and sees the same wires.
  endstop_watch watch (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .raw_pins_i       (raw_pins),
    .dir_negative_i   (dir_negative),
    .axis_moving_i    (axis_moving),
    .homing_i         (homing),
    .clear_hits_i     (clear_hits),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .sampled_levels_i (sampled_levels),
    .hit_flags_i      (hit_flags),
    .stop_axes_i      (stop_axes),
    .abort_move_i     (abort_move),
    .fault_count_o    (fault_count),
    .outstanding_o    (outstanding)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Writes all five registers back to back. The small registers get random
  // junk in their unused upper data bits, which the monitor has to drop.
  task automatic load_config(input etm_cfg_t c);
    logic [CfgIdxW-1:0] idx [5];
    logic [NumPins-1:0] val [5];
    logic [31:0]        junk;
    junk   = $urandom;
    idx[0] = CfgInvertMask;
    idx[1] = CfgPresentMask;
    idx[2] = CfgZSwitchCnt;
    idx[3] = CfgProbeMode;
    idx[4] = CfgProbeEnable;
    val[0] = c.invert_mask;
    val[1] = c.present_mask;
    val[2] = {junk[9:0], c.z_switch_count};
    val[3] = {junk[20:10], c.probe_mode};
    val[4] = {junk[31:20], c.probe_enable};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offers one request and holds it until the monitor takes it. Valid stays
  // high into the next request unless a random idle burst follows.
  task automatic send_tick(input logic [NumPins-1:0] raw, input logic [NumAxes-1:0] neg,
                           input logic [NumAxes-1:0] mov, input logic hom, input logic clr);
    in_valid     <= 1'b1;
    raw_pins     <= raw;
    dir_negative <= neg;
    axis_moving  <= mov;
    homing       <= hom;
    clear_hits   <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  // Every request yields a result, so the monitor is idle after that.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side. Random bursts of stall and flow, one long hold-off once the
  // sender is well under way so that the monitor fills and stalls its input,
  // and a steady flow in the last part of the run.
  initial begin : result_side
    int span;
    forever begin
      if (!hold_done && sent_count >= 150) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        span = $urandom_range(1, 13);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    etm_cfg_t           cfg;
    logic [NumPins-1:0] raw;
    logic [NumAxes-1:0] neg;
    logic [NumAxes-1:0] mov;
    logic               hom;
    logic               clr;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration first: a single switch per axis.
    // Two active samples in a row trigger the max switches, then the min ones.
    send_tick('0, 3'b000, 3'b111, 1'b0, 1'b0);
    send_tick('1, 3'b000, 3'b111, 1'b0, 1'b0);
    send_tick('1, 3'b000, 3'b111, 1'b0, 1'b0);
    send_tick('1, 3'b111, 3'b111, 1'b0, 1'b0);
    send_tick('1, 3'b111, 3'b111, 1'b0, 1'b0);
    // Clearing the hits while nothing moves: active levels but no new hits.
    send_tick('1, 3'b111, 3'b000, 1'b0, 1'b1);
    send_tick('0, 3'b111, 3'b111, 1'b1, 1'b0);
    settle();

    // All pins present and inverted, four Z switches, separate probe enabled.
    // All Z switches together while homing abort; a partial set does not.
    cfg.invert_mask    = '1;
    cfg.present_mask   = '1;
    cfg.z_switch_count = 3'd4;
    cfg.probe_mode     = ProbeSeparate;
    cfg.probe_enable   = 1'b1;
    load_config(cfg);
    send_tick('0, 3'b100, 3'b100, 1'b1, 1'b0);
    send_tick('0, 3'b100, 3'b100, 1'b1, 1'b0);
    send_tick(13'h0080, 3'b100, 3'b100, 1'b1, 1'b1);
    send_tick(13'h0080, 3'b100, 3'b100, 1'b0, 1'b0);
    settle();

    // Primary Z pins absent with two Z switches: the whole Z test is skipped.
    cfg.present_mask   = 13'h0003;
    cfg.z_switch_count = 3'd2;
    cfg.probe_mode     = ProbeOnZMin;
    cfg.probe_enable   = 1'b0;
    load_config(cfg);
    send_tick('0, 3'b000, 3'b111, 1'b0, 1'b0);
    send_tick('0, 3'b000, 3'b111, 1'b0, 1'b0);
    settle();

    // Switch count above the maximum, extra Z pins absent and copying Z min.
    cfg.invert_mask    = '0;
    cfg.present_mask   = PresentReset;
    cfg.z_switch_count = 3'd7;
    load_config(cfg);
    send_tick('1, 3'b100, 3'b100, 1'b0, 1'b0);
    send_tick('1, 3'b100, 3'b100, 1'b0, 1'b0);
    settle();

    // Probe on the Z min pin with a single switch: Z min is read only when
    // probing is enabled.
    cfg.z_switch_count = 3'd1;
    load_config(cfg);
    send_tick('1, 3'b100, 3'b100, 1'b0, 1'b0);
    send_tick('1, 3'b100, 3'b100, 1'b0, 1'b0);
    settle();
    cfg.probe_enable = 1'b1;
    load_config(cfg);
    send_tick('1, 3'b100, 3'b100, 1'b0, 1'b0);
    send_tick('1, 3'b100, 3'b100, 1'b0, 1'b0);
    settle();

    // A switch count of zero acts as one; the unused probe mode acts as none.
    cfg.z_switch_count = 3'd0;
    cfg.probe_mode     = 2'd3;
    load_config(cfg);
    send_tick('1, 3'b100, 3'b111, 1'b0, 1'b0);
    send_tick('1, 3'b100, 3'b111, 1'b0, 1'b0);
    settle();

    // Random part. Pin levels mostly hold for several ticks, as real
    // switches do, so that double-sample triggers keep happening; now and
    // then a single pin flips or the whole word changes.
    raw = '0;
    neg = '0;
    mov = '1;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin
          cfg.invert_mask    = '0;
          cfg.present_mask   = '0;
          cfg.z_switch_count = 3'd0;
          cfg.probe_mode     = ProbeNone;
          cfg.probe_enable   = 1'b0;
        end
        1: begin
          cfg.invert_mask    = '1;
          cfg.present_mask   = '1;
          cfg.z_switch_count = 3'd7;
          cfg.probe_mode     = 2'd3;
          cfg.probe_enable   = 1'b1;
        end
        default: begin
          cfg.invert_mask = NumPins'($urandom);
          case ($urandom_range(0, 3))
            0:       cfg.present_mask = '1;
            1:       cfg.present_mask = PresentReset;
            default: cfg.present_mask = NumPins'($urandom);
          endcase
          cfg.z_switch_count = 3'($urandom_range(0, 7));
          cfg.probe_mode     = 2'($urandom_range(0, 3));
          cfg.probe_enable   = 1'($urandom_range(0, 1));
        end
      endcase
      // The last phase runs with both sides flowing freely.
      if (phase == RandomPhases - 1) calm = 1'b1;
      load_config(cfg);
      for (int n = 0; n < PhaseTicks; n++) begin
        case ($urandom_range(0, 7))
          0:       raw = NumPins'($urandom);
          1:       raw[$urandom_range(0, NumPins - 1)] ^= 1'b1;
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0) neg = NumAxes'($urandom);
        if ($urandom_range(0, 3) == 0) mov = NumAxes'($urandom);
        hom = ($urandom_range(0, 3) == 0);
        clr = ($urandom_range(0, 15) == 0);
        send_tick(raw, neg, mov, hom, clr);
      end
      settle();
    end

    // Let a few more cycles pass so that any stray result is still caught.
    repeat (5) @(posedge clk);
    if (fault_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
